/* hw/rtl/gpg_pkg.sv */
`default_nettype none

package gpg_pkg;

    // Field widths
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int STEPS_W = 7;

    // Step count limits and reset value
    localparam int STEPS_MIN   = 2;
    localparam int STEPS_MAX   = 64;
    localparam int STEPS_RESET = 30;

    // Segment divisor (steps - 1) and step counter width
    localparam int DIV_W = $clog2(STEPS_MAX);

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS  = CHAN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STEPS = REG_IDX_W'(0);

    typedef struct packed {
        logic [COLOR_W-1:0] base_color;
        logic               last_base;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] palette_color;
        logic               last_entry;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_GEN  = 3'b100
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic gen_step;
        logic emit;
        logic seg_done;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             have_prev;
        logic             dup;
        logic [DIV_W-1:0] seg_div;
    } t_status;

    // Clamp the step count and return steps - 1
    function automatic logic [DIV_W-1:0] clamp_div(input logic [STEPS_W-1:0] steps);
        logic [DIV_W-1:0] res;
        if (steps < STEPS_W'(STEPS_MIN)) begin
            res = DIV_W'(STEPS_MIN - 1);
        end else if (steps > STEPS_W'(STEPS_MAX)) begin
            res = DIV_W'(STEPS_MAX - 1);
        end else begin
            res = DIV_W'(steps - STEPS_W'(1));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gradient_palette_generator_top.sv */
`default_nettype none

// Gradient palette generator. Feed base colors (RGB888) one per input
// transaction and mark the final color of each palette with last_base. The
// first color of a palette produces nothing; every later color produces the
// ramp from the previous color to it in N = steps_per_segment entries (held
// to 2..64), dropping any entry equal to the one just sent, and an entry
// of the final segment that equals the final color carries last_entry. A
// first color is only loaded; a segment color is loaded, then each
// channel's span is divided by N - 1 bit-serially (one quotient bit per
// cycle), then the ramp is stepped, each step a single add and compare
// against the remainder. Output stalls hold only steps that emit.
// steps_per_segment sits at byte address 0 of the APB port and resets
// to 30; write it only while no segment is running.
module gradient_palette_generator_top
    import gpg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [STEPS_W-1:0] r_steps;
    logic [REG_IDX_W-1:0] reg_idx;
    t_cmd    cmd;
    t_status status;

    // Register file
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_W'(STEPS_RESET);
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_STEPS)) begin
            r_steps <= pwdata[STEPS_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_STEPS) ? APB_DATA_W'(r_steps) : '0;

    gpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gpg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_in_data),
        .i_steps    (r_steps),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

/* hw/rtl/gpg_datapath.sv */
`default_nettype none

module gpg_datapath
    import gpg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire t_in_item           i_item,
    input  wire logic [STEPS_W-1:0] i_steps,
    output t_status                 o_status,
    output t_out_item               o_out_data
);

    // Palette state
    logic [COLOR_W-1:0] r_prev_base;
    logic               r_have_prev;
    logic [COLOR_W-1:0] r_last_emitted;
    logic               r_have_emitted;

    // Segment working registers
    logic [COLOR_W-1:0] r_c1;
    logic [COLOR_W-1:0] r_c2;
    logic               r_ends;
    logic [DIV_W-1:0]   r_div;

    // Per-channel divider and accumulator
    logic [NUM_CH-1:0]             r_dir;
    logic [CHAN_W-1:0]             r_dvd [NUM_CH];
    logic [DIV_W-1:0]              r_rem [NUM_CH];
    logic [CHAN_W-1:0]             r_q   [NUM_CH];
    logic [DIV_W-1:0]              r_r   [NUM_CH];

    t_out_item r_out_data;

    logic [COLOR_W-1:0] entry;
    logic [CHAN_W-1:0]  ch_a    [NUM_CH];
    logic [CHAN_W-1:0]  ch_b    [NUM_CH];
    logic [CHAN_W-1:0]  ch_ent  [NUM_CH];
    logic [DIV_W:0]     rem_sh  [NUM_CH];
    logic               rem_ge  [NUM_CH];
    logic [DIV_W:0]     rem_sum [NUM_CH];
    logic               carry   [NUM_CH];

    // Per-channel arithmetic
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            ch_a[c] = r_prev_base[c*CHAN_W +: CHAN_W];
            ch_b[c] = i_item.base_color[c*CHAN_W +: CHAN_W];
            // Downward ramps round toward minus infinity, away from the start color
            if (r_dir[c]) begin
                ch_ent[c] = r_c1[c*CHAN_W +: CHAN_W] - r_q[c]
                            - {{(CHAN_W-1){1'b0}}, (r_r[c] != '0)};
            end else begin
                ch_ent[c] = r_c1[c*CHAN_W +: CHAN_W] + r_q[c];
            end
            entry[c*CHAN_W +: CHAN_W] = ch_ent[c];
            // Divider step: shift in next dividend bit, subtract if it fits
            rem_sh[c] = {r_rem[c], r_dvd[c][CHAN_W-1]};
            rem_ge[c] = rem_sh[c] >= {1'b0, r_div};
            // Accumulate remainder, carry into quotient on overflow
            rem_sum[c] = {1'b0, r_r[c]} + {1'b0, r_rem[c]};
            carry[c]   = rem_sum[c] >= {1'b0, r_div};
        end
    end

    // Palette state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_base    <= '0;
            r_have_prev    <= 1'b0;
            r_last_emitted <= '0;
            r_have_emitted <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_base <= i_item.base_color;
                r_have_prev <= !i_item.last_base;
            end
            // Palette end wins over the last emit
            if (i_cmd.seg_done && r_ends) begin
                r_last_emitted <= '0;
                r_have_emitted <= 1'b0;
            end else if (i_cmd.emit) begin
                r_last_emitted <= entry;
                r_have_emitted <= 1'b1;
            end
        end
    end

    // Segment setup, division and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c1   <= r_prev_base;
            r_c2   <= i_item.base_color;
            r_ends <= i_item.last_base;
            r_div  <= clamp_div(i_steps);
        end
        for (int c = 0; c < NUM_CH; c++) begin
            if (i_cmd.load) begin
                r_dir[c] <= ch_b[c] < ch_a[c];
                r_dvd[c] <= (ch_b[c] < ch_a[c]) ? (ch_a[c] - ch_b[c]) : (ch_b[c] - ch_a[c]);
                r_rem[c] <= '0;
                r_q[c]   <= '0;
                r_r[c]   <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[c] <= rem_ge[c] ? DIV_W'(rem_sh[c] - {1'b0, r_div})
                                      : rem_sh[c][DIV_W-1:0];
                r_dvd[c] <= {r_dvd[c][CHAN_W-2:0], rem_ge[c]};
            end else if (i_cmd.gen_step) begin
                r_r[c] <= carry[c] ? DIV_W'(rem_sum[c] - {1'b0, r_div})
                                   : rem_sum[c][DIV_W-1:0];
                r_q[c] <= r_q[c] + r_dvd[c] + {{(CHAN_W-1){1'b0}}, carry[c]};
            end
        end
    end

    // Output register; ramps are monotonic, so an emit equal to the end color is the segment's final emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.palette_color <= entry;
            r_out_data.last_entry    <= r_ends && (entry == r_c2);
        end
    end

    assign o_status.have_prev = r_have_prev;
    assign o_status.dup       = r_have_emitted && (entry == r_last_emitted);
    assign o_status.seg_div   = r_div;
    assign o_out_data         = r_out_data;

endmodule

`default_nettype wire

/* hw/rtl/gpg_ctrl.sv */
`default_nettype none

module gpg_ctrl
    import gpg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [DIV_W-1:0]      r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Sequence one item: accept, then for a segment color divide and generate
    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_step    = r_step;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.have_prev) begin
                        n_state   = S_DIV;
                        n_div_cnt = '0;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_LAST) begin
                    n_state = S_GEN;
                    n_step  = '0;
                end
            end
            S_GEN: begin
                // Skip repeats freely; emit only into a free output slot
                if (i_status.dup || out_free) begin
                    o_cmd.gen_step = 1'b1;
                    o_cmd.emit     = !i_status.dup;
                    n_step         = r_step + DIV_W'(1);
                    if (r_step == i_status.seg_div) begin
                        o_cmd.seg_done = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold output valid until the transaction completes
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/gpg_checker.sv */
`default_nettype none

module gpg_checker
    import gpg_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire t_out_item             o_out_data,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // No new result appears while the block sits idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && $past(o_in_ready) |-> !$rose(o_out_valid))
        else $error("result produced while idle");

    // Step count reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1:2] == REG_STEPS)
        |=> (paddr[APB_ADDR_W-1:2] != REG_STEPS)
            || (prdata[STEPS_W-1:0] == $past(pwdata[STEPS_W-1:0])))
        else $error("step count readback mismatch");

    // Unused register bits read as zero
    a_cfg_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[APB_DATA_W-1:STEPS_W] == '0)
        else $error("reserved register bits set");

endmodule

bind gradient_palette_generator_top gpg_checker u_checker (.*);

`default_nettype wire

/* tb/gradient_palette_generator_top_tb.sv */
`default_nettype none

module gradient_palette_generator_top_tb;
    import gpg_pkg::*;

    localparam int CLK_PERIOD  = 8;
    // longest unstalled segment: load, bit-serial divide, then one ramp step per cycle
    localparam int SEG_CYCLES  = 1 + DIV_STEPS + STEPS_MAX;
    localparam int SETTLE      = 2 * SEG_CYCLES;
    localparam int HOLD_CYCLES = 500;
    localparam int RUN_LIMIT   = 500_000 * CLK_PERIOD;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    t_in_item              in_data    = '0;
    logic                  out_ready  = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gradient_palette_generator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Pending base colors, expected palette entries, error count
    t_in_item  base_queue[$];
    t_out_item expected_entries[$];
    int        mismatch_count = 0;
    logic      in_fire        = 1'b0;
    int        hold_reqs      = 0;

    // Gradient model state
    logic [STEPS_W-1:0] steps_reg     = STEPS_W'(STEPS_RESET);
    logic [COLOR_W-1:0] prev_base     = '0;
    logic               have_prev     = 1'b0;
    logic [COLOR_W-1:0] last_emit     = '0;
    logic               have_emit     = 1'b0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // One channel: a + floor((b - a) * j / div), rounded toward minus infinity
    function automatic logic [CHAN_W-1:0] blend_channel(input int a, input int b,
                                                        input int j, input int div);
        int res;
        if (b >= a) begin
            res = a + ((b - a) * j) / div;
        end else begin
            res = a - (((a - b) * j + div - 1) / div);
        end
        return CHAN_W'(res);
    endfunction

    function automatic logic [COLOR_W-1:0] blend_color(input logic [COLOR_W-1:0] c1,
                                                       input logic [COLOR_W-1:0] c2,
                                                       input int j, input int div);
        return {blend_channel(int'(c1[23:16]), int'(c2[23:16]), j, div),
                blend_channel(int'(c1[15:8]),  int'(c2[15:8]),  j, div),
                blend_channel(int'(c1[7:0]),   int'(c2[7:0]),   j, div)};
    endfunction

    // Expand one base color into its ramp entries and advance the palette state
    task automatic ramp_segment(input t_in_item item);
        int                 n;
        int                 j;
        logic [COLOR_W-1:0] c;
        t_out_item          held;
        logic               have_held;
        have_held = 1'b0;
        held      = '0;
        if (have_prev) begin
            n = int'(steps_reg);
            if (n < STEPS_MIN) n = STEPS_MIN;
            if (n > STEPS_MAX) n = STEPS_MAX;
            for (j = 0; j < n; j++) begin
                c = blend_color(prev_base, item.base_color, j, n - 1);
                if (!have_emit || c != last_emit) begin
                    if (have_held) expected_entries.push_back(held);
                    held.palette_color = c;
                    held.last_entry    = 1'b0;
                    have_held          = 1'b1;
                    last_emit          = c;
                    have_emit          = 1'b1;
                end
            end
            if (have_held) begin
                held.last_entry = item.last_base;
                expected_entries.push_back(held);
            end
        end
        prev_base = item.base_color;
        if (item.last_base) begin
            have_prev = 1'b0;
            last_emit = '0;
            have_emit = 1'b0;
        end else begin
            have_prev = 1'b1;
        end
    endtask

    // Check output transactions, then record accepted input transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_entries.size() == 0) begin
                    $error("unexpected palette entry %06h last %0b",
                           out_data.palette_color, out_data.last_entry);
                    mismatch_count++;
                end else begin
                    if (out_data.palette_color !== expected_entries[0].palette_color) begin
                        $error("palette_color expected %06h actual %06h",
                               expected_entries[0].palette_color, out_data.palette_color);
                        mismatch_count++;
                    end
                    if (out_data.last_entry !== expected_entries[0].last_entry) begin
                        $error("last_entry expected %0b actual %0b",
                               expected_entries[0].last_entry, out_data.last_entry);
                        mismatch_count++;
                    end
                    void'(expected_entries.pop_front());
                end
            end
            if (in_valid && in_ready) ramp_segment(in_data);
        end
        in_fire <= i_rst_n && in_valid && in_ready;
    end

    // Drive base colors in bursts separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        if (in_valid && !in_fire) begin
            // hold the offered transaction
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (i_rst_n && base_queue.size() != 0) begin
            in_valid <= 1'b1;
            in_data  <= base_queue.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Stall the output on a pattern of its own, with long hold-offs on request
    int       hold_served = 0;
    int       hold_left   = 0;
    int       mode_left   = 0;
    t_rx_mode rx_mode     = RX_OPEN;
    always @(negedge i_clk) begin
        if (hold_reqs != hold_served) begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Write the step count, then read it back
    task automatic write_steps(input logic [STEPS_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STEPS, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        steps_reg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_W'(value)) begin
            $error("steps_per_segment expected %0d actual %0d", value, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait for every transaction to be taken and every entry to arrive
    task automatic drain();
        while (base_queue.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color(input logic [COLOR_W-1:0] prev);
        int                 roll;
        logic [COLOR_W-1:0] c;
        int                 k;
        roll = $urandom_range(0, 9);
        c    = COLOR_W'($urandom());
        if (roll == 5) begin
            c = prev;
        end else if (roll == 6) begin
            for (k = 0; k < NUM_CH; k++) c[k*CHAN_W +: CHAN_W] = {CHAN_W{1'($urandom())}};
        end else if (roll == 7) begin
            for (k = 0; k < NUM_CH; k++)
                c[k*CHAN_W +: CHAN_W] = prev[k*CHAN_W +: CHAN_W] + CHAN_W'($urandom_range(0, 4))
                                        - CHAN_W'($urandom_range(0, 4));
        end else if (roll == 8) begin
            c = '0;
        end else if (roll == 9) begin
            k = $urandom_range(0, NUM_CH - 1);
            c = prev;
            c[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom());
        end
        return c;
    endfunction

    task automatic push_base(input logic [COLOR_W-1:0] color, input logic ends);
        t_in_item item;
        item.base_color = color;
        item.last_base  = ends;
        base_queue.push_back(item);
    endtask

    // Queue random palettes and stray transactions until at least target colors are queued
    task automatic queue_random(input int target);
        int                 added;
        int                 len;
        int                 k;
        logic [COLOR_W-1:0] c;
        added = 0;
        c     = COLOR_W'($urandom());
        while (added < target) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    c = pick_color(c);
                    push_base(c, k == len - 1);
                end
                added += len;
            end else begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) push_base(COLOR_W'($urandom()), 1'($urandom()));
                added += len;
            end
        end
    endtask

    logic [STEPS_W-1:0] settings[12] = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd65,
                                         7'd17, 7'd3, 7'd64, 7'd2, 7'd40, 7'd30};

    initial begin
        int p;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed palettes at the reset step count
        push_base(24'h123456, 1'b1);                  // one-color palette
        push_base(24'h000000, 1'b0);                  // black to white
        push_base(24'hFFFFFF, 1'b1);
        push_base(24'hFFFFFF, 1'b0);                  // falling then mixed
        push_base(24'h000000, 1'b0);
        push_base(24'hFF00FF, 1'b1);
        push_base(24'h000000, 1'b0);                  // zero color, final segment all repeats
        push_base(24'h0000FF, 1'b0);
        push_base(24'h0000FF, 1'b1);
        push_base(24'hA5A5A5, 1'b0);                  // repeated base mid-palette
        push_base(24'hA5A5A5, 1'b0);
        push_base(24'h5A0FF0, 1'b1);
        push_base(24'h808080, 1'b0);                  // tiny spans, many repeats
        push_base(24'h7F7F81, 1'b1);
        push_base(24'h102030, 1'b0);                  // leave this palette open
        push_base(24'hC0A050, 1'b0);
        drain();

        // Change the step count in the middle of the open palette
        write_steps(7'd2);
        push_base(24'h00FF00, 1'b1);
        push_base(24'h000000, 1'b0);
        push_base(24'h010203, 1'b0);
        push_base(24'h010203, 1'b1);
        drain();

        // Random phases over a spread of step counts
        for (p = 0; p < 12; p++) begin
            write_steps(settings[p]);
            if (p == 1) hold_reqs++;
            queue_random(14);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/gpg_pkg.sv
hw/rtl/gpg_datapath.sv
hw/rtl/gpg_ctrl.sv
hw/rtl/gradient_palette_generator_top.sv
hw/rtl/gpg_checker.sv
tb/gradient_palette_generator_top_tb.sv
